[rtl/core/sjfs_pkg.sv]
// ----------------------------------------------------------------------------
// sjfs_pkg
// Types and codes shared by the scheduler controller, datapath and top level.
// ----------------------------------------------------------------------------
package sjfs_pkg;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_START  = 2'd1,
        EV_REJECT = 2'd2
    } t_event;

    typedef enum logic {
        CMD_SUBMIT = 1'b0,
        CMD_TICK   = 1'b1
    } t_command;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the input beat, restart index and best-so-far
        logic idx_inc;    // step the slot index
        logic sub_write;  // store the job in the slot at the index
        logic reject;     // mark the submit as rejected
        logic rd_en;      // read the slot at the index into the compare stage
        logic sub_done;   // build the submit result
        logic tick_done;  // commit the tick and build its result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;  // slot at the index holds no job
        logic idx_last;   // index points at the last slot
        logic rem_zero;   // server is free
    } t_dp_sts;

endpackage

[rtl/core/shortest_job_first_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit
// Non-preemptive shortest-job-first scheduler for one server.
// ----------------------------------------------------------------------------
// Each input beat is a submit or a one-second tick and yields exactly one
// result beat. A submit stores the job in the first free slot of a table of
// TABLE_DEPTH slots, found by stepping through the slots one per cycle; a
// full table rejects it. A tick while the server is busy skips the scan. A
// tick while the server is free scans every slot through the one read port
// of the job table, one slot per cycle; it starts the job with the fewest
// pages, the earliest arrival winning ties, and the server then stays busy
// for that many ticks counting the starting one. A finished result sits in
// an output register, so the next beat is taken while it waits for the
// downstream side.
module shortest_job_first_scheduler_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // doc_id [15:0], pages [31:16]
    input  logic        s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // started_id [15:0], busy_res [16], zero [23:17]
    output logic [1:0]  m_axis_tuser    // event_res [1:0]
);
    import sjfs_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [15:0] w_started_id;
    logic        w_busy;

    sjfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_command   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    sjfs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_doc_id     (s_axis_tdata[15:0]),
        .i_pages      (s_axis_tdata[31:16]),
        .o_event      (m_axis_tuser),
        .o_started_id (w_started_id),
        .o_busy       (w_busy)
    );

    assign m_axis_tdata = {7'd0, w_busy, w_started_id};

endmodule

[rtl/core/sjfs_dpath.sv]
// ----------------------------------------------------------------------------
// sjfs_dpath
// Job table, arrival counter, work counter, minimum search stage and the
// result registers of the scheduler.
// ----------------------------------------------------------------------------
module sjfs_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sjfs_pkg::t_dp_cmd i_cmd,
    output sjfs_pkg::t_dp_sts o_sts,
    input  logic [15:0]       i_doc_id,
    input  logic [15:0]       i_pages,
    output logic [1:0]        o_event,
    output logic [15:0]       o_started_id,
    output logic              o_busy
);
    import sjfs_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [IW-1:0]          r_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [15:0]            r_mem_id    [TABLE_DEPTH];
    logic [15:0]            r_mem_len   [TABLE_DEPTH];
    logic [31:0]            r_mem_stamp [TABLE_DEPTH];

    logic [15:0] r_doc_id;
    logic [15:0] r_pages;
    logic        r_reject;
    logic [31:0] r_next_stamp;
    logic [15:0] r_rem;

    logic          r_rd_act;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [15:0]   r_rd_id;
    logic [15:0]   r_rd_len;
    logic [31:0]   r_rd_stamp;

    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [15:0]   r_best_len;
    logic [31:0]   r_best_age;
    logic [15:0]   r_best_id;

    t_event      r_event;
    logic [15:0] r_started_id;
    logic        r_busy;

    logic [31:0] w_age;
    logic        w_better;

    assign o_sts.slot_free = !r_valid[r_idx];
    assign o_sts.idx_last  = (r_idx == IW'(TABLE_DEPTH - 1));
    assign o_sts.rem_zero  = (r_rem == 16'd0);

    // A larger age means an earlier arrival; ties on length go to the oldest.
    assign w_age    = r_next_stamp - r_rd_stamp;
    assign w_better = r_rd_act && r_rd_vld &&
                      (!r_found || (r_rd_len < r_best_len) ||
                       ((r_rd_len == r_best_len) && (w_age > r_best_age)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_doc_id <= i_doc_id;
            r_pages  <= i_pages;
        end
        if (i_cmd.capture) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.capture) begin
            r_reject <= 1'b0;
        end else if (i_cmd.reject) begin
            r_reject <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_write) begin
            r_mem_id[r_idx]    <= r_doc_id;
            r_mem_len[r_idx]   <= r_pages;
            r_mem_stamp[r_idx] <= r_next_stamp;
        end
        if (i_cmd.rd_en) begin
            r_rd_id    <= r_mem_id[r_idx];
            r_rd_len   <= r_mem_len[r_idx];
            r_rd_stamp <= r_mem_stamp[r_idx];
            r_rd_vld   <= r_valid[r_idx];
            r_rd_idx   <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_next_stamp <= '0;
            r_rem        <= '0;
            r_rd_act     <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_rd_act <= i_cmd.rd_en;
            if (i_cmd.sub_write) begin
                r_valid[r_idx] <= 1'b1;
                r_next_stamp   <= r_next_stamp + 32'd1;
            end
            if (i_cmd.capture) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.tick_done) begin
                if (r_rem != 16'd0) begin
                    r_rem <= r_rem - 16'd1;
                end else if (r_found) begin
                    r_valid[r_best_idx] <= 1'b0;
                    r_rem <= (r_best_len == 16'd0) ? 16'd0 : r_best_len - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_better) begin
            r_best_idx <= r_rd_idx;
            r_best_len <= r_rd_len;
            r_best_age <= w_age;
            r_best_id  <= r_rd_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_done) begin
            r_event      <= r_reject ? EV_REJECT : EV_NONE;
            r_started_id <= 16'd0;
            r_busy       <= (r_rem != 16'd0);
        end else if (i_cmd.tick_done) begin
            if (r_rem != 16'd0) begin
                r_event      <= EV_NONE;
                r_started_id <= 16'd0;
                r_busy       <= (r_rem != 16'd1);
            end else if (r_found) begin
                r_event      <= EV_START;
                r_started_id <= r_best_id;
                r_busy       <= (r_best_len > 16'd1);
            end else begin
                r_event      <= EV_NONE;
                r_started_id <= 16'd0;
                r_busy       <= 1'b0;
            end
        end
    end

    assign o_event      = r_event;
    assign o_started_id = r_started_id;
    assign o_busy       = r_busy;

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sub_write |-> !r_valid[r_idx])
        else $error("job written over an occupied slot");

    a_stamp_only_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.sub_write |=> $stable(r_next_stamp))
        else $error("arrival counter moved without a stored job");

    a_started_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_done && (r_rem == 16'd0) && r_found) |=> !r_valid[$past(r_best_idx)])
        else $error("started job still occupies its slot");

endmodule

[rtl/core/sjfs_ctrl.sv]
// ----------------------------------------------------------------------------
// sjfs_ctrl
// Sequencer of the scheduler: accepts a beat, runs the free-slot search or
// the minimum scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sjfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sjfs_pkg::t_dp_cmd o_cmd,
    input  sjfs_pkg::t_dp_sts i_sts
);
    import sjfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_SCAN,
        ST_SUB_DONE,
        ST_TICK_SCAN,
        ST_TICK_LAST,
        ST_TICK_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (t_command'(i_command) == CMD_SUBMIT) begin
                        n_state = ST_SUB_SCAN;
                    end else if (i_sts.rem_zero) begin
                        n_state = ST_TICK_SCAN;
                    end else begin
                        n_state = ST_TICK_DONE;
                    end
                end
            end
            ST_SUB_SCAN: begin
                if (i_sts.slot_free) begin
                    o_cmd.sub_write = 1'b1;
                    n_state = ST_SUB_DONE;
                end else if (i_sts.idx_last) begin
                    o_cmd.reject = 1'b1;
                    n_state = ST_SUB_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_SUB_DONE: begin
                if (w_out_free) begin
                    o_cmd.sub_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_TICK_LAST;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            // The last slot read is still in the compare stage here.
            ST_TICK_LAST: begin
                n_state = ST_TICK_DONE;
            end
            ST_TICK_DONE: begin
                if (w_out_free) begin
                    o_cmd.tick_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.sub_done || o_cmd.tick_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[dv/shortest_job_first_scheduler_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit_test
// Self-checking bench for the shortest-job-first scheduler. A scoreboard class
// keeps its own copy of the job table and the server countdown, predicts one
// result per accepted input beat and checks every output beat in order. The
// stimulus is a short directed sequence followed by random submit/tick
// traffic with random idling on both streams.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_unit_test;
    import sjfs_pkg::*;

    localparam int TABLE_SLOTS   = 16;
    localparam int RANDOM_BEATS  = 750;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 2 * TABLE_SLOTS + 16;

    typedef struct {
        t_event      ev;
        logic [15:0] doc_id;
        logic        busy;
    } t_sched_result;

    class sjf_scoreboard;
        bit            slot_taken [TABLE_SLOTS];
        logic [15:0]   slot_doc   [TABLE_SLOTS];
        logic [15:0]   slot_len   [TABLE_SLOTS];
        logic [31:0]   slot_stamp [TABLE_SLOTS];
        logic [31:0]   arrival_count;
        logic [15:0]   ticks_left;
        logic [15:0]   last_started_len;
        t_sched_result expected_q [$];
        int            mismatches;

        function new();
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            arrival_count    = '0;
            ticks_left       = '0;
            last_started_len = '0;
            mismatches       = 0;
        endfunction

        function int jobs_waiting();
            int n;
            n = 0;
            foreach (slot_taken[i]) if (slot_taken[i]) n++;
            return n;
        endfunction

        // Updates the table for one accepted beat and queues the result it causes.
        function void note_beat(t_command cmd, logic [15:0] doc_id, logic [15:0] pages);
            t_sched_result r;
            int            pick;
            logic [31:0]   age;
            logic [31:0]   best_age;
            r.ev     = EV_NONE;
            r.doc_id = '0;
            pick     = -1;
            best_age = '0;
            if (cmd == CMD_SUBMIT) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (pick < 0 && !slot_taken[i]) pick = i;
                end
                if (pick < 0) begin
                    r.ev = EV_REJECT;
                end else begin
                    slot_taken[pick] = 1'b1;
                    slot_doc[pick]   = doc_id;
                    slot_len[pick]   = pages;
                    slot_stamp[pick] = arrival_count;
                    arrival_count    = arrival_count + 1;
                end
            end else begin
                if (ticks_left == 0) begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (slot_taken[i]) begin
                            age = arrival_count - slot_stamp[i];
                            if (pick < 0 || slot_len[i] < slot_len[pick] ||
                                (slot_len[i] == slot_len[pick] && age > best_age)) begin
                                pick     = i;
                                best_age = age;
                            end
                        end
                    end
                    if (pick >= 0) begin
                        slot_taken[pick] = 1'b0;
                        ticks_left       = slot_len[pick];
                        last_started_len = slot_len[pick];
                        r.ev             = EV_START;
                        r.doc_id         = slot_doc[pick];
                    end
                end
                // The starting tick counts as the first tick of the job.
                if (ticks_left != 0) ticks_left = ticks_left - 1;
            end
            r.busy = (ticks_left != 0);
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        endtask

        task check_result(logic [23:0] tdata, logic [1:0] tuser);
            t_sched_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", '0, {tuser, tdata});
            end else begin
                want = expected_q.pop_front();
                if (tuser !== want.ev)
                    report_mismatch("event_res", want.ev, tuser);
                if (tdata[15:0] !== want.doc_id)
                    report_mismatch("started_id", want.doc_id, tdata[15:0]);
                if (tdata[16] !== want.busy)
                    report_mismatch("busy_res", want.busy, tdata[16]);
                if (tdata[23:17] !== 7'd0)
                    report_mismatch("tdata padding", 0, tdata[23:17]);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // doc_id [15:0], pages [31:16]
    logic        s_axis_tuser;   // command [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // started_id [15:0], busy_res [16], zero [23:17]
    logic [1:0]  m_axis_tuser;   // event_res [1:0]

    sjf_scoreboard sb;
    bit            idle_on;
    int            cycle_count = 0;

    shortest_job_first_scheduler_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Downstream side: stalls come in bursts while idling is enabled.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(t_command cmd, logic [15:0] doc_id, logic [15:0] pages);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {pages, doc_id};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(cmd, doc_id, pages);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic submit_job(logic [15:0] doc_id, logic [15:0] pages);
        send_beat(CMD_SUBMIT, doc_id, pages);
    endtask

    // Tick beats carry random data, which the block has to ignore.
    task automatic tick();
        send_beat(CMD_TICK, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] random_pages();
        if ($urandom_range(0, 15) == 0) return 16'd0;
        return 16'($urandom_range(1, 10));
    endfunction

    initial begin
        int submit_pct;
        sb            = new();
        idle_on       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SUBMIT;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty tick, zero-page job, tie on length, submit while
        // busy, then a full table and a rejected submit.
        idle_on = 1'b1;
        tick();
        submit_job(16'h0000, 16'd0);
        tick();
        submit_job(16'hFFFF, 16'd3);
        submit_job(16'h00FF, 16'd2);
        submit_job(16'hFF00, 16'd2);
        submit_job(16'h8000, 16'd1);
        tick();
        tick();
        submit_job(16'h0F0F, 16'd1);
        tick();
        tick();
        repeat (TABLE_SLOTS - sb.jobs_waiting()) submit_job(16'($urandom), random_pages());
        submit_job(16'hA5A5, 16'd4);

        // Random part: the submit share changes every segment so that the table
        // swings between empty and full.
        submit_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        submit_pct = 25;
                    end
                    1: begin
                        submit_pct = 50;
                    end
                    default: begin
                        submit_pct = 80;
                    end
                endcase
                idle_on = (n < RANDOM_BEATS * 85 / 100) && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(1, 100) <= submit_pct)
                submit_job(16'($urandom), random_pages());
            else
                tick();
        end

        // Tail: drain the table, then run the longest possible job.
        idle_on = 1'b0;
        while (sb.jobs_waiting() != 0) tick();
        submit_job(16'hFFFF, 16'hFFFF);
        while (sb.last_started_len != 16'hFFFF) tick();
        submit_job(16'h1357, 16'd5);
        tick();
        tick();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
